// ===== design/circular_deque_assert.svh =====
// ----------------------------------------------------------------------------
// circular deque assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property checked at every edge outside reset
`define CDQ_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("circular_deque assertion failed");
// property checked at every edge, reset included
`define CDQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("circular_deque assertion failed");
`else
`define CDQ_ASSERT_RST(label, clk, rst_n, prop)
`define CDQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== design/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// shared sizes, codes, types and ring index helpers of the circular deque
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK       = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic exec;      // apply the command to indices, count and store
    logic load_out;  // fill the result register
  } dp_cmd_t;

  function automatic idx_t ring_next(input idx_t i);
    ring_next = (i == idx_t'(CAPACITY - 1)) ? '0 : idx_t'(i + idx_t'(1));
  endfunction

  function automatic idx_t ring_prev(input idx_t i);
    ring_prev = (i == '0) ? idx_t'(CAPACITY - 1) : idx_t'(i - idx_t'(1));
  endfunction

endpackage

`default_nettype wire

// ===== design/cdq_if.sv =====
// ----------------------------------------------------------------------------
// cdq channel interfaces
// valid/ready channels for commands and results of the circular deque
// ----------------------------------------------------------------------------
`default_nettype none

interface cdq_in_if;
  logic                        valid;
  logic                        ready;
  logic [cdq_pkg::CMD_W-1:0]   command;
  logic [cdq_pkg::DATA_WIDTH-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface cdq_out_if;
  logic                           valid;
  logic                           ready;
  logic [cdq_pkg::STATUS_W-1:0]   status;
  logic [cdq_pkg::DATA_WIDTH-1:0] front_value;
  logic [cdq_pkg::DATA_WIDTH-1:0] back_value;
  logic [cdq_pkg::CNT_W-1:0]      occupancy;
  logic                           is_empty;
  logic                           is_full;

  modport source (output valid, output status, output front_value, output back_value,
                  output occupancy, output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input front_value, input back_value,
                  input occupancy, input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// ===== design/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// sequencer: capture, execute, load result; owns the output valid flag
// ----------------------------------------------------------------------------
`default_nettype none

`include "circular_deque_assert.svh"

module cdq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cdq_pkg::dp_cmd_t      dp_cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    dp_cmd.capture  = in_valid && in_ready;
    dp_cmd.exec     = (state_r == S_EXEC);
    dp_cmd.load_out = (state_r == S_LOAD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // in S_LOAD a taken result is replaced by the new one below
      if (out_valid_r && out_ready && (state_r != S_LOAD)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // an accepted command always moves on to execution
  `CDQ_ASSERT_RST(a_accept_exec, clk, rst_n, (in_valid && in_ready) |=> (state_r == S_EXEC))
  // a result is loaded only into a free output register
  `CDQ_ASSERT_RST(a_load_free, clk, rst_n, dp_cmd.load_out |-> (!out_valid_r || out_ready))
  // a waiting result stays valid until its transfer
  `CDQ_ASSERT_RST(a_out_hold, clk, rst_n, (out_valid_r && !out_ready) |=> out_valid_r)

endmodule

`default_nettype wire

// ===== design/cdq_datapath.sv =====
// ----------------------------------------------------------------------------
// cdq_datapath
// ring store, head/tail indices, item count and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "circular_deque_assert.svh"

module cdq_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire cdq_pkg::dp_cmd_t               dp_cmd,
  input  wire logic [cdq_pkg::CMD_W-1:0]      in_command,
  input  wire logic [cdq_pkg::DATA_WIDTH-1:0] in_value,
  output logic [cdq_pkg::STATUS_W-1:0]        out_status,
  output logic [cdq_pkg::DATA_WIDTH-1:0]      out_front_value,
  output logic [cdq_pkg::DATA_WIDTH-1:0]      out_back_value,
  output logic [cdq_pkg::CNT_W-1:0]           out_occupancy,
  output logic                                out_is_empty,
  output logic                                out_is_full
);

  cdq_pkg::data_t mem [cdq_pkg::CAPACITY];

  logic [cdq_pkg::CMD_W-1:0] cmd_r;
  cdq_pkg::data_t            val_r;
  cdq_pkg::idx_t             head_r, head_nxt;
  cdq_pkg::idx_t             tail_r, tail_nxt;
  cdq_pkg::cnt_t             cnt_r, cnt_nxt;
  cdq_pkg::status_t          status_r, status_nxt;
  logic                      we;
  cdq_pkg::idx_t             waddr;
  logic                      is_full, is_empty;

  logic [cdq_pkg::STATUS_W-1:0] out_status_r;
  cdq_pkg::data_t               front_r, back_r;
  cdq_pkg::cnt_t                occ_r;
  logic                         empty_r, full_r;

  assign is_full  = (cnt_r == cdq_pkg::cnt_t'(cdq_pkg::CAPACITY));
  assign is_empty = (cnt_r == '0);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    status_nxt = cdq_pkg::ST_DONE;
    we         = 1'b0;
    waddr      = tail_r;
    case (cmd_r)
      cdq_pkg::CMD_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = cdq_pkg::ST_FULL;
        end else begin
          head_nxt = cdq_pkg::ring_prev(head_r);
          waddr    = head_nxt;
          we       = 1'b1;
          cnt_nxt  = cdq_pkg::cnt_t'(cnt_r + cdq_pkg::cnt_t'(1));
        end
      end
      cdq_pkg::CMD_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = cdq_pkg::ST_FULL;
        end else begin
          waddr    = tail_r;
          we       = 1'b1;
          tail_nxt = cdq_pkg::ring_next(tail_r);
          cnt_nxt  = cdq_pkg::cnt_t'(cnt_r + cdq_pkg::cnt_t'(1));
        end
      end
      cdq_pkg::CMD_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = cdq_pkg::ST_EMPTY;
        end else begin
          head_nxt = cdq_pkg::ring_next(head_r);
          cnt_nxt  = cdq_pkg::cnt_t'(cnt_r - cdq_pkg::cnt_t'(1));
        end
      end
      cdq_pkg::CMD_POP_BACK: begin
        if (is_empty) begin
          status_nxt = cdq_pkg::ST_EMPTY;
        end else begin
          tail_nxt = cdq_pkg::ring_prev(tail_r);
          cnt_nxt  = cdq_pkg::cnt_t'(cnt_r - cdq_pkg::cnt_t'(1));
        end
      end
      default: begin
        // peek and unused codes change nothing
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else if (dp_cmd.exec) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // payload and store
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_r <= in_command;
      val_r <= in_value;
    end
    if (dp_cmd.exec) begin
      status_r <= status_nxt;
      if (we) begin
        mem[waddr] <= val_r;
      end
    end
    if (dp_cmd.load_out) begin
      out_status_r <= status_r;
      occ_r        <= cnt_r;
      empty_r      <= is_empty;
      full_r       <= is_full;
      front_r      <= is_empty ? '0 : mem[head_r];
      back_r       <= is_empty ? '0 : mem[cdq_pkg::ring_prev(tail_r)];
    end
  end

  assign out_status      = out_status_r;
  assign out_front_value = front_r;
  assign out_back_value  = back_r;
  assign out_occupancy   = occ_r;
  assign out_is_empty    = empty_r;
  assign out_is_full     = full_r;

  // count never passes capacity
  `CDQ_ASSERT_RST(a_cnt_range, clk, rst_n, cnt_r <= cdq_pkg::cnt_t'(cdq_pkg::CAPACITY))
  // head and tail meet exactly when the ring is empty or full
  `CDQ_ASSERT_RST(a_ends_meet, clk, rst_n, (is_empty || is_full) |-> (head_r == tail_r))
  // count only moves on an execute step
  `CDQ_ASSERT_RST(a_cnt_hold, clk, rst_n, !dp_cmd.exec |=> $stable(cnt_r))

endmodule

`default_nettype wire

// ===== design/circular_deque.sv =====
// result path: a result becomes valid after its command transfer by way of the execute
//   step, then the load step, which waits until the output register is free
// command flow: a new command is taken only once the controller sequence around the
//   single-write ring store is back in idle; the next command is taken while a result still waits
// reset: synchronous, active low; clears head, tail, count, sequencer and output valid
//   the ring store is not cleared, only occupied entries are ever read
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue over a fixed ring store, one status result per command
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cdq_in_if.sink     in_ch,
  cdq_out_if.source  out_ch
);

  // command bundle from sequencer to datapath
  cdq_pkg::dp_cmd_t dp_cmd;

  // sequencer: takes a command transfer only when idle, so the item in
  // flight always sees indices settled by the one before it
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dp_cmd    (dp_cmd)
  );

  // datapath: ring store with one write and two registered reads
  // (front at head, back just before tail), plus the result register
  cdq_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .dp_cmd          (dp_cmd),
    .in_command      (in_ch.command),
    .in_value        (in_ch.value),
    .out_status      (out_ch.status),
    .out_front_value (out_ch.front_value),
    .out_back_value  (out_ch.back_value),
    .out_occupancy   (out_ch.occupancy),
    .out_is_empty    (out_ch.is_empty),
    .out_is_full     (out_ch.is_full)
  );

endmodule

`default_nettype wire
